@@ hw/rtl/dics_pkg.sv @@
// Shared types, constants and codes for the discrete inverse-CDF sampler.
package dics_pkg;

   localparam int VALUE_BITS    = 16;
   localparam int WEIGHT_BITS   = 16;
   localparam int FRACTION_BITS = 16;
   localparam int FRAC_IN_BITS  = FRACTION_BITS + 1;
   localparam int TOTAL_BITS    = 24;
   localparam int INDEX_BITS    = 8;
   localparam int STATUS_BITS   = 2;
   localparam int LHS_BITS      = FRAC_IN_BITS + TOTAL_BITS;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_NO_MATCH = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;
      logic write;
      logic search_init;
      logic set_empty;
      logic probe;
      logic step;
      logic fetch;
      logic set_nomatch;
      logic set_ok;
      logic publish;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_load;
      logic total_zero;
      logic search_done;
      logic no_match;
   } dp_stat_type;

endpackage

@@ hw/rtl/dics_datapath.sv @@
// Datapath: table memories, running counts, product register and bisection bounds.
module dics_datapath #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dics_pkg::ctl_cmd_type             cmd,
   output dics_pkg::dp_stat_type             stat,
   input  logic                              in_cmd,
   input  logic                              in_restart,
   input  logic [dics_pkg::VALUE_BITS-1:0]   in_entry_value,
   input  logic [dics_pkg::WEIGHT_BITS-1:0]  in_entry_weight,
   input  logic [dics_pkg::FRAC_IN_BITS-1:0] in_random_fraction,
   output logic [dics_pkg::VALUE_BITS-1:0]   out_sample_value,
   output logic [dics_pkg::INDEX_BITS-1:0]   out_sample_index,
   output logic [dics_pkg::STATUS_BITS-1:0]  out_status
);
   import dics_pkg::*;

   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [VALUE_BITS-1:0]   value_mem_ff [MAX_ENTRIES];
   logic [TOTAL_BITS-1:0]   cum_mem_ff   [MAX_ENTRIES];

   logic                    item_cmd_ff;
   logic                    item_restart_ff;
   logic [VALUE_BITS-1:0]   item_value_ff;
   logic [WEIGHT_BITS-1:0]  item_weight_ff;
   logic [FRAC_IN_BITS-1:0] item_frac_ff;

   logic [CNT_W-1:0]        entries_ff, entries_in;
   logic [TOTAL_BITS-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi_ff, hi_in;
   logic [CNT_W-1:0]        mid_ff;
   logic [LHS_BITS-1:0]     lhs_ff;
   logic [TOTAL_BITS-1:0]   cum_rd_ff;
   logic [VALUE_BITS-1:0]   value_rd_ff;

   logic [VALUE_BITS-1:0]   res_value_ff;
   logic [INDEX_BITS-1:0]   res_index_ff;
   status_type              res_status_ff;
   logic [VALUE_BITS-1:0]   out_value_ff;
   logic [INDEX_BITS-1:0]   out_index_ff;
   status_type              out_status_ff;

   logic [CNT_W-1:0]        base_count;
   logic [TOTAL_BITS-1:0]   base_total;
   logic                    full;
   logic [TOTAL_BITS:0]     total_sum;
   logic [TOTAL_BITS-1:0]   new_total;
   logic [CNT_W:0]          mid_sum;
   logic [CNT_W-1:0]        mid_in;
   logic                    below;
   logic                    mem_we;

   always_comb begin
      base_count = item_restart_ff ? '0 : entries_ff;
      base_total = item_restart_ff ? '0 : total_ff;
      full       = (base_count == CNT_W'(MAX_ENTRIES));
      total_sum  = {1'b0, base_total} + (TOTAL_BITS + 1)'(item_weight_ff);
      new_total  = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
      mem_we     = cmd.write && !full;
      mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff};
      mid_in     = mid_sum[CNT_W:1];
      below      = lhs_ff < LHS_BITS'({cum_rd_ff, {FRACTION_BITS{1'b0}}});
   end

   always_comb begin
      entries_in = entries_ff;
      total_in   = total_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      if (mem_we) begin
         entries_in = base_count + CNT_W'(1);
         total_in   = new_total;
      end
      if (cmd.search_init) begin
         lo_in = '0;
         hi_in = entries_ff;
      end
      if (cmd.step) begin
         if (below) begin
            hi_in = mid_ff;
         end else begin
            lo_in = mid_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
         total_ff   <= '0;
         lo_ff      <= '0;
         hi_ff      <= '0;
      end else begin
         entries_ff <= entries_in;
         total_ff   <= total_in;
         lo_ff      <= lo_in;
         hi_ff      <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         value_mem_ff[base_count[IDX_W-1:0]] <= item_value_ff;
         cum_mem_ff[base_count[IDX_W-1:0]]   <= new_total;
      end
      if (cmd.probe) begin
         cum_rd_ff <= cum_mem_ff[mid_in[IDX_W-1:0]];
      end
      if (cmd.fetch) begin
         value_rd_ff <= value_mem_ff[lo_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_cmd_ff     <= in_cmd;
         item_restart_ff <= in_restart;
         item_value_ff   <= in_entry_value;
         item_weight_ff  <= in_entry_weight;
         item_frac_ff    <= in_random_fraction;
      end
      if (cmd.search_init) begin
         lhs_ff <= LHS_BITS'(item_frac_ff) * LHS_BITS'(total_ff);
      end
      if (cmd.probe) begin
         mid_ff <= mid_in;
      end
      if (cmd.write) begin
         res_value_ff  <= '0;
         res_index_ff  <= full ? '0 : INDEX_BITS'(32'(base_count));
         res_status_ff <= full ? STATUS_FULL : STATUS_OK;
      end
      if (cmd.set_empty || cmd.set_nomatch) begin
         res_value_ff  <= '0;
         res_index_ff  <= '0;
         res_status_ff <= cmd.set_empty ? STATUS_EMPTY : STATUS_NO_MATCH;
      end
      if (cmd.set_ok) begin
         res_value_ff  <= value_rd_ff;
         res_index_ff  <= INDEX_BITS'(32'(lo_ff));
         res_status_ff <= STATUS_OK;
      end
      if (cmd.publish) begin
         out_value_ff  <= res_value_ff;
         out_index_ff  <= res_index_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign stat.is_load     = (item_cmd_ff == CMD_LOAD);
   assign stat.total_zero  = (total_ff == '0);
   assign stat.search_done = (lo_ff >= hi_ff);
   assign stat.no_match    = (lo_ff == entries_ff);

   assign out_sample_value = out_value_ff;
   assign out_sample_index = out_index_ff;
   assign out_status       = out_status_ff;

`ifndef ASSERT_OFF
   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      lo_ff <= hi_ff)
      else $error("search lower bound passed upper bound");
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      entries_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond table depth");
   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      (entries_ff == '0) |-> (total_ff == '0))
      else $error("nonzero total with empty table");
   a_step_narrows: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (hi_ff - lo_ff) < ($past(hi_ff) - $past(lo_ff)))
      else $error("bisection step did not narrow the interval");
`endif

endmodule

@@ hw/rtl/dics_ctrl.sv @@
// Controller: sequences load, multiply, bisection probes, value fetch and output handoff.
module dics_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output dics_pkg::ctl_cmd_type cmd,
   input  dics_pkg::dp_stat_type stat
);
   import dics_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PROBE,
      ST_COMPARE,
      ST_FETCH,
      ST_FETCH_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
         end
         ST_DECODE: begin
            cmd.write       = stat.is_load;
            cmd.set_empty   = !stat.is_load && stat.total_zero;
            cmd.search_init = !stat.is_load && !stat.total_zero;
         end
         ST_PROBE: begin
            cmd.probe = !stat.search_done;
         end
         ST_COMPARE: begin
            cmd.step = 1'b1;
         end
         ST_FETCH: begin
            cmd.fetch       = !stat.no_match;
            cmd.set_nomatch = stat.no_match;
         end
         ST_FETCH_WAIT: begin
            cmd.set_ok = 1'b1;
         end
         ST_FINISH: begin
            cmd.publish = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready && !cmd.publish) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               if (stat.is_load || stat.total_zero) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_PROBE;
               end
            end
            ST_PROBE: begin
               state_ff <= stat.search_done ? ST_FETCH : ST_COMPARE;
            end
            ST_COMPARE: begin
               state_ff <= ST_PROBE;
            end
            ST_FETCH: begin
               state_ff <= stat.no_match ? ST_FINISH : ST_FETCH_WAIT;
            end
            ST_FETCH_WAIT: begin
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_publish_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");
   a_publish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not marked valid");
   a_single_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command in a cycle");
`endif

endmodule

@@ hw/rtl/discrete_inverse_cdf_sampler.sv @@
// Top level: discrete inverse-CDF sampler with load and sample commands on one stream.
// A load beat, or a sample on an empty table, goes from decode straight to finish; a sample
// search alternates probe and compare states, then fetch (and fetch wait on a match) to finish.
// One beat is in flight at a time; each bisection step is a memory read plus a compare.
// The result register frees the input side while a finished result waits downstream.
// Reset (synchronous, active high) empties the table and zeroes the total; no clearing pass.
module discrete_inverse_cdf_sampler #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // entry_value, entry_weight, random_fraction, zero pad
   input  logic [1:0]  req_tuser,   // cmd, restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // sample_value, sample_index
   output logic [1:0]  rsp_tuser    // status
);
   import dics_pkg::*;

   ctl_cmd_type             cmd;
   dp_stat_type             stat;
   logic [VALUE_BITS-1:0]   sample_value;
   logic [INDEX_BITS-1:0]   sample_index;
   logic [STATUS_BITS-1:0]  status;

   dics_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   dics_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .in_cmd             (req_tuser[0]),
      .in_restart         (req_tuser[1]),
      .in_entry_value     (req_tdata[15:0]),
      .in_entry_weight    (req_tdata[31:16]),
      .in_random_fraction (req_tdata[48:32]),
      .out_sample_value   (sample_value),
      .out_sample_index   (sample_index),
      .out_status         (status)
   );

   assign rsp_tdata = {sample_index, sample_value};
   assign rsp_tuser = status;

endmodule
